// ----- design/block_buffer_pool_lru_defines.svh -----
// assertion macros for the buffer pool tag store
// no dependencies; included by the files that carry checks
`ifndef BLOCK_BUFFER_POOL_LRU_DEFINES_SVH
`define BLOCK_BUFFER_POOL_LRU_DEFINES_SVH

`ifndef ASSERT_OFF
// check sampled at the clock, ignored while reset is held
`define BPLRU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// check sampled at every clock, reset included
`define BPLRU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define BPLRU_ASSERT(label, clk, rst_n, prop)
`define BPLRU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/bplru_pkg.sv -----
// shared types and constants of the buffer pool tag store
// no dependencies; used by the interfaces, the scan unit, the top level and the testbench
package bplru_pkg;

    localparam int FUNC_W  = 3;
    localparam int FILE_W  = 16;
    localparam int BLOCK_W = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int DROP_W  = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INV_FILE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INV_BLOCK = 3'd4;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // one tag ram entry; the valid bit lives in flops
    typedef struct packed {
        logic               dirty;
        logic [FILE_W-1:0]  file_id;
        logic [BLOCK_W-1:0] block_offset;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FILE_W-1:0]  file_id;
        logic [BLOCK_W-1:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               fill_needed;
        logic               writeback_needed;
        logic [FILE_W-1:0]  victim_file;
        logic [BLOCK_W-1:0] victim_block;
        logic [DROP_W-1:0]  dropped_count;
    } t_res;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic start;
        logic eval;
        logic exclude;
        logic inv_file;
        logic inv_block;
    } t_scan_ctl;

    // summary flags from the scan unit
    typedef struct packed {
        logic hit;
        logic hit_dirty;
        logic inv_found;
        logic drop;
    } t_scan_flags;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

endpackage

// ----- design/bplru_req_if.sv -----
// request channel of the buffer pool tag store
// depends on bplru_pkg
interface bplru_req_if;
    import bplru_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [FILE_W-1:0]  file_id;
    logic [BLOCK_W-1:0] block_offset;

    modport source (output valid, output func, output file_id, output block_offset,
                    input ready);
    modport sink   (input valid, input func, input file_id, input block_offset,
                    output ready);
endinterface

// ----- design/bplru_res_if.sv -----
// result channel of the buffer pool tag store
// depends on bplru_pkg
interface bplru_res_if;
    import bplru_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               fill_needed;
    logic               writeback_needed;
    logic [FILE_W-1:0]  victim_file;
    logic [BLOCK_W-1:0] victim_block;
    logic [DROP_W-1:0]  dropped_count;

    modport source (output valid, output slot, output hit, output fill_needed,
                    output writeback_needed, output victim_file, output victim_block,
                    output dropped_count, input ready);
    modport sink   (input valid, input slot, input hit, input fill_needed,
                    input writeback_needed, input victim_file, input victim_block,
                    input dropped_count, output ready);
endinterface

// ----- design/bplru_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module bplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/bplru_scan.sv -----
// scan unit: folds one tag entry per cycle into hit, free slot, lru victim and drop count
// depends on bplru_pkg
module bplru_scan #(
    parameter int SLOTS = 16
) (
    input  logic                                  i_clk,
    input  bplru_pkg::t_scan_ctl                  i_ctl,
    input  logic [bplru_pkg::FILE_W-1:0]          i_file,
    input  logic [bplru_pkg::BLOCK_W-1:0]         i_block,
    input  logic [$clog2(SLOTS)-1:0]              i_idx,
    input  logic                                  i_live,
    input  bplru_pkg::t_entry                     i_entry,
    output bplru_pkg::t_scan_flags                o_flags,
    output logic [$clog2(SLOTS)-1:0]              o_hit_idx,
    output logic [$clog2(SLOTS)-1:0]              o_inv_idx,
    output logic [$clog2(SLOTS)-1:0]              o_best_idx,
    output bplru_pkg::t_entry                     o_best,
    output logic [$clog2(SLOTS+1)-1:0]            o_drop_cnt
);
    import bplru_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic          r_hit, r_hit_dirty, r_inv_found, r_best_found;
    logic [IW-1:0] r_hit_idx, r_inv_idx, r_best_idx;
    t_entry        r_best;
    logic [CW-1:0] r_drop_cnt;

    logic file_eq, block_eq, match, drop, cand, older;

    // per-entry compares
    always_comb begin
        file_eq  = (i_entry.file_id == i_file);
        block_eq = (i_entry.block_offset == i_block);
        match    = i_live && file_eq && block_eq;
        drop     = i_ctl.eval && i_live && file_eq &&
                   (i_ctl.inv_file || (i_ctl.inv_block && block_eq));
        cand     = !(i_ctl.exclude && file_eq);
        older    = !r_best_found || (i_entry.stamp < r_best.stamp);
    end

    // accumulate over the scan; start clears the summary
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hit        <= 1'b0;
            r_inv_found  <= 1'b0;
            r_best_found <= 1'b0;
            r_drop_cnt   <= '0;
        end else if (i_ctl.eval) begin
            if (match && !r_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= i_idx;
                r_hit_dirty <= i_entry.dirty;
            end
            if (!i_live && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_idx   <= i_idx;
            end
            // slot 0 is the fallback victim when every slot is excluded
            if (i_idx == '0) begin
                r_best       <= i_entry;
                r_best_idx   <= i_idx;
                r_best_found <= cand;
            end else if (cand && older) begin
                r_best       <= i_entry;
                r_best_idx   <= i_idx;
                r_best_found <= 1'b1;
            end
            if (drop) begin
                r_drop_cnt <= r_drop_cnt + CW'(1);
            end
        end
    end

    assign o_flags    = '{hit: r_hit, hit_dirty: r_hit_dirty, inv_found: r_inv_found,
                          drop: drop};
    assign o_hit_idx  = r_hit_idx;
    assign o_inv_idx  = r_inv_idx;
    assign o_best_idx = r_best_idx;
    assign o_best     = r_best;
    assign o_drop_cnt = r_drop_cnt;
endmodule

// ----- design/block_buffer_pool_lru.sv -----
// Tag store and LRU replacement of a block buffer pool with SLOTS slots. Entries
// (dirty, file, block, use stamp) sit in one tag ram; valid bits are flops cleared
// by reset, so the pool is usable straight after reset with no clearing pass. One
// request is handled at a time: the scan reads the tag ram one slot per cycle
// through its registered read port, the finish state of a read, write or alloc
// writes the chosen slot back once the output register is free, and the block
// then returns to idle, where it takes the next request. The result sits in an
// output register, so a new request is taken while it waits.
// depends on bplru_pkg, bplru_req_if, bplru_res_if, bplru_ram, bplru_scan
`include "block_buffer_pool_lru_defines.svh"

module block_buffer_pool_lru #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bplru_req_if.sink   i_req,
    bplru_res_if.source o_res
);
    import bplru_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [CW-1:0]        r_cnt;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic [SLOTS-1:0]     r_valid;
    logic [STAMP_W-1:0]   r_use_cnt;
    logic                 r_out_vld;
    t_res                 r_res;

    logic                 req_xfer, issue, scan_done, fin_go;
    logic                 is_rw, is_write, is_alloc, is_inv, hit, claim, wb;
    logic [IW-1:0]        s;
    logic [STAMP_W-1:0]   stamp_next;
    logic [IW+SLOT_W-1:0] s_ext;
    logic [CW+DROP_W-1:0] drop_ext;
    t_entry               rd_entry, wr_entry, best;
    t_scan_ctl            ctl;
    t_scan_flags          flags;
    logic [IW-1:0]        hit_idx, inv_idx, best_idx;
    logic [CW-1:0]        drop_cnt;
    logic [ENTRY_W-1:0]   rd_data;
    t_res                 res;

    // request decode
    always_comb begin
        is_write = (r_req.func == FN_WRITE);
        is_rw    = (r_req.func == FN_READ) || is_write;
        is_alloc = (r_req.func == FN_ALLOC);
        is_inv   = (r_req.func == FN_INV_FILE) || (r_req.func == FN_INV_BLOCK);
    end

    // handshakes and scan sequencing
    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign issue       = (r_state == ST_SCAN) && (r_cnt != CW'(SLOTS));
    assign scan_done   = r_rd_vld && (r_rd_idx == IW'(SLOTS - 1));
    assign fin_go      = (r_state == ST_FIN) && (!r_out_vld || o_res.ready);

    always_comb begin
        ctl.start     = req_xfer;
        ctl.eval      = r_rd_vld;
        ctl.exclude   = is_rw;
        ctl.inv_file  = (r_req.func == FN_INV_FILE);
        ctl.inv_block = (r_req.func == FN_INV_BLOCK);
    end

    bplru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (fin_go && claim),
        .i_waddr (s),
        .i_wdata (wr_entry),
        .i_re    (issue),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    bplru_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_file     (r_req.file_id),
        .i_block    (r_req.block_offset),
        .i_idx      (r_rd_idx),
        .i_live     (r_valid[r_rd_idx]),
        .i_entry    (rd_entry),
        .o_flags    (flags),
        .o_hit_idx  (hit_idx),
        .o_inv_idx  (inv_idx),
        .o_best_idx (best_idx),
        .o_best     (best),
        .o_drop_cnt (drop_cnt)
    );

    // slot choice, write-back entry and result
    always_comb begin
        hit   = is_rw && flags.hit;
        claim = is_rw || is_alloc;
        priority if (hit) begin
            s = hit_idx;
        end else if (flags.inv_found) begin
            s = inv_idx;
        end else begin
            s = best_idx;
        end
        wb         = claim && !hit && !flags.inv_found && best.dirty;
        stamp_next = (r_use_cnt == STAMP_MAX) ? r_use_cnt : r_use_cnt + STAMP_W'(1);

        wr_entry.dirty        = is_write || is_alloc || (hit && flags.hit_dirty);
        wr_entry.file_id      = r_req.file_id;
        wr_entry.block_offset = r_req.block_offset;
        wr_entry.stamp        = stamp_next;

        s_ext    = {{SLOT_W{1'b0}}, s};
        drop_ext = {{DROP_W{1'b0}}, drop_cnt};

        res                  = '0;
        res.slot             = claim ? s_ext[SLOT_W-1:0] : '0;
        res.hit              = hit;
        res.fill_needed      = is_rw && !hit;
        res.writeback_needed = wb;
        res.victim_file      = wb ? best.file_id : '0;
        res.victim_block     = wb ? best.block_offset : '0;
        res.dropped_count    = is_inv ? drop_ext[DROP_W-1:0] : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_xfer) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (fin_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_use_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (req_xfer) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            // invalidate drops during the scan, claims set at the end
            if (flags.drop) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
            if (fin_go && claim) begin
                r_valid[s] <= 1'b1;
                r_use_cnt  <= stamp_next;
            end
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_req.func         <= i_req.func;
            r_req.file_id      <= i_req.file_id;
            r_req.block_offset <= i_req.block_offset;
        end
        if (issue) begin
            r_rd_idx <= r_cnt[IW-1:0];
        end
        if (fin_go) begin
            r_res <= res;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.slot             = r_res.slot;
    assign o_res.hit              = r_res.hit;
    assign o_res.fill_needed      = r_res.fill_needed;
    assign o_res.writeback_needed = r_res.writeback_needed;
    assign o_res.victim_file      = r_res.victim_file;
    assign o_res.victim_block     = r_res.victim_block;
    assign o_res.dropped_count    = r_res.dropped_count;

    // checks
    `BPLRU_ASSERT(a_xfer_starts_scan, i_clk, i_rst_n, req_xfer |=> (r_state == ST_SCAN))
    `BPLRU_ASSERT(a_result_after_fin, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(fin_go))
    `BPLRU_ASSERT(a_hit_no_fill, i_clk, i_rst_n, r_out_vld |-> !(r_res.hit && r_res.fill_needed))
    `BPLRU_ASSERT(a_wb_only_on_miss, i_clk, i_rst_n, (r_out_vld && r_res.writeback_needed) |-> !r_res.hit)
    `BPLRU_ASSERT(a_use_cnt_monotone, i_clk, i_rst_n, i_rst_n |=> (r_use_cnt >= $past(r_use_cnt)))
endmodule

// ----- dv/block_buffer_pool_lru_tb.sv -----
// self-checking testbench of the buffer pool tag store: directed and random requests,
// results compared field by field against a behavioural model of the lru pool
// depends on bplru_pkg, bplru_req_if, bplru_res_if and block_buffer_pool_lru
module block_buffer_pool_lru_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bplru_pkg::*;

    localparam int SLOTS           = 16;
    localparam int SCAN_CYCLES     = SLOTS + 3;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 100;

    // func codes the block does not use
    localparam logic [FUNC_W-1:0]  FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0]  FN_SPARE_HI = 3'd7;
    localparam logic [FILE_W-1:0]  FILE_MAX    = '1;
    localparam logic [BLOCK_W-1:0] BLOCK_MAX   = '1;
    localparam logic [FILE_W-1:0]  FILE_SOLO   = 16'hA5A5;
    localparam logic [FILE_W-1:0]  FILE_OTHER  = 16'h5A5A;

    logic i_clk;
    logic i_rst_n;

    bplru_req_if req_if ();
    bplru_res_if res_if ();

    block_buffer_pool_lru #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // model of the tag store
    logic               pool_valid [SLOTS];
    logic               pool_dirty [SLOTS];
    logic [FILE_W-1:0]  pool_file  [SLOTS];
    logic [BLOCK_W-1:0] pool_block [SLOTS];
    logic [STAMP_W-1:0] pool_stamp [SLOTS];
    logic [STAMP_W-1:0] use_count;

    t_res pending_results [$];

    // idling and back-pressure control
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_request;
    int holds_done;

    // random working set, kept small so that hits and evictions are frequent
    logic [FILE_W-1:0]  work_files  [4];
    logic [BLOCK_W-1:0] work_blocks [12];
    int n_work_files;
    int n_work_blocks;

    // statistics
    int mismatches;
    int items_sent;
    int results_checked;
    int hits_seen;
    int fills_seen;
    int writebacks_seen;
    int drops_seen;
    int spare_seen;
    int quiet_cycles;

    function automatic logic [STAMP_W-1:0] bump_use_count();
        if (use_count != STAMP_MAX)
            use_count = use_count + 1'b1;
        return use_count;
    endfunction

    // first free slot, else least recently used slot, optionally of another file
    function automatic int choose_victim(input bit exclude_file,
                                         input logic [FILE_W-1:0] file_id);
        int  best;
        bit  found;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (!pool_valid[i])
                return i;
        for (int i = 0; i < SLOTS; i++) begin
            if (exclude_file && pool_file[i] == file_id)
                continue;
            if (!found || pool_stamp[i] < pool_stamp[best]) begin
                best  = i;
                found = 1'b1;
            end
        end
        return best;
    endfunction

    // take a slot for the block, reporting a dirty victim
    function automatic int claim_slot(input bit exclude_file, input t_req r, inout t_res res);
        int s;
        s = choose_victim(exclude_file, r.file_id);
        if (pool_valid[s] && pool_dirty[s]) begin
            res.writeback_needed = 1'b1;
            res.victim_file      = pool_file[s];
            res.victim_block     = pool_block[s];
        end
        pool_valid[s] = 1'b1;
        pool_dirty[s] = 1'b0;
        pool_file[s]  = r.file_id;
        pool_block[s] = r.block_offset;
        return s;
    endfunction

    // expected result of one request; updates the model state
    function automatic t_res predict_pool_result(input t_req r);
        t_res res;
        int   s;
        int   dropped;
        bit   found;
        res     = '0;
        s       = 0;
        dropped = 0;
        found   = 1'b0;
        case (r.func)
            FN_READ, FN_WRITE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && pool_valid[i] && pool_file[i] == r.file_id
                        && pool_block[i] == r.block_offset) begin
                        s     = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    res.hit = 1'b1;
                end else begin
                    s = claim_slot(1'b1, r, res);
                    res.fill_needed = 1'b1;
                end
                if (r.func == FN_WRITE)
                    pool_dirty[s] = 1'b1;
                pool_stamp[s] = bump_use_count();
                res.slot = s[SLOT_W-1:0];
            end
            FN_ALLOC: begin
                s = claim_slot(1'b0, r, res);
                pool_dirty[s] = 1'b1;
                pool_stamp[s] = bump_use_count();
                res.slot = s[SLOT_W-1:0];
            end
            FN_INV_FILE, FN_INV_BLOCK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (pool_valid[i] && pool_file[i] == r.file_id
                        && (r.func == FN_INV_FILE || pool_block[i] == r.block_offset)) begin
                        pool_valid[i] = 1'b0;
                        pool_dirty[i] = 1'b0;
                        dropped++;
                    end
                end
                res.dropped_count = dropped[DROP_W-1:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < MAX_REPORTS)
            $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // one request transfer; the valid stays high so that back-to-back items need no gap
    task automatic send_req(input t_req r);
        t_res want;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= r.func;
        req_if.file_id      <= r.file_id;
        req_if.block_offset <= r.block_offset;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        want = predict_pool_result(r);
        pending_results.push_back(want);
        items_sent++;
        if (want.hit)              hits_seen++;
        if (want.fill_needed)      fills_seen++;
        if (want.writeback_needed) writebacks_seen++;
        if (want.dropped_count != 0) drops_seen++;
        if (r.func >= FN_SPARE_LO) spare_seen++;
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [FILE_W-1:0] file_id,
                           input logic [BLOCK_W-1:0] block_offset);
        t_req r;
        r.func         = func;
        r.file_id      = file_id;
        r.block_offset = block_offset;
        send_req(r);
    endtask

    // lower the request and wait for every outstanding result
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic refresh_working_set();
        n_work_files  = $urandom_range(1, 4);
        n_work_blocks = $urandom_range(3, 12);
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 9))
                0:       work_files[i] = '0;
                1:       work_files[i] = FILE_MAX;
                default: work_files[i] = FILE_W'($urandom());
            endcase
        end
        for (int i = 0; i < 12; i++) begin
            case ($urandom_range(0, 9))
                0:       work_blocks[i] = '0;
                1:       work_blocks[i] = BLOCK_MAX;
                2:       work_blocks[i] = BLOCK_W'($urandom_range(0, 31));
                default: work_blocks[i] = $urandom();
            endcase
        end
    endtask

    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 34)      r.func = FN_READ;
        else if (pick < 64) r.func = FN_WRITE;
        else if (pick < 76) r.func = FN_ALLOC;
        else if (pick < 88) r.func = FN_INV_BLOCK;
        else if (pick < 96) r.func = FN_INV_FILE;
        else                r.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        // a few requests outside the working set
        if ($urandom_range(0, 99) < 6) begin
            r.file_id      = FILE_W'($urandom());
            r.block_offset = $urandom();
        end else begin
            r.file_id      = work_files[$urandom_range(0, n_work_files - 1)];
            r.block_offset = work_blocks[$urandom_range(0, n_work_blocks - 1)];
        end
        return r;
    endfunction

    // every operation on an empty pool, duplicates and unused codes
    task automatic test_basic_ops();
        send_op(FN_READ,      FILE_MAX, BLOCK_MAX);
        send_op(FN_WRITE,     FILE_MAX, BLOCK_MAX);
        send_op(FN_ALLOC,     FILE_MAX, BLOCK_MAX);
        send_op(FN_READ,      FILE_MAX, BLOCK_MAX);
        send_op(FN_INV_BLOCK, FILE_MAX, BLOCK_MAX);
        send_op(FN_WRITE,     '0,       '0);
        send_op(FN_INV_FILE,  '0,       BLOCK_MAX);
        send_op(FN_SPARE_LO,  FILE_MAX, BLOCK_MAX);
        send_op(FN_SPARE_HI,  FILE_MAX, BLOCK_MAX);
    endtask

    // pool full of one file: a miss of that file evicts slot 0, then drop all sixteen
    task automatic test_single_file_pool();
        for (int i = 0; i < SLOTS; i++)
            send_op(FN_WRITE, FILE_SOLO, BLOCK_W'(i));
        send_op(FN_READ,     FILE_SOLO,  BLOCK_W'(SLOTS));
        send_op(FN_INV_FILE, FILE_SOLO,  '0);
        send_op(FN_READ,     FILE_OTHER, BLOCK_MAX);
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                refresh_working_set();
            send_req(random_req());
        end
    endtask

    // result side held off while requests keep coming
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_off_request = 1'b1;
        for (int i = 0; i < 30; i++)
            send_req(random_req());
    endtask

    // result sink with random stalls and an optional long hold-off
    initial begin : result_sink
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
                hold_off_request = 1'b0;
                holds_done++;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.slot             = res_if.slot;
            got.hit              = res_if.hit;
            got.fill_needed      = res_if.fill_needed;
            got.writeback_needed = res_if.writeback_needed;
            got.victim_file      = res_if.victim_file;
            got.victim_block     = res_if.victim_block;
            got.dropped_count    = res_if.dropped_count;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, slot", got.slot, 0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.slot !== want.slot)
                    report_mismatch("slot", got.slot, want.slot);
                if (got.hit !== want.hit)
                    report_mismatch("hit", got.hit, want.hit);
                if (got.fill_needed !== want.fill_needed)
                    report_mismatch("fill_needed", got.fill_needed, want.fill_needed);
                if (got.writeback_needed !== want.writeback_needed)
                    report_mismatch("writeback_needed", got.writeback_needed,
                                    want.writeback_needed);
                if (got.victim_file !== want.victim_file)
                    report_mismatch("victim_file", got.victim_file, want.victim_file);
                if (got.victim_block !== want.victim_block)
                    report_mismatch("victim_block", got.victim_block, want.victim_block);
                if (got.dropped_count !== want.dropped_count)
                    report_mismatch("dropped_count", got.dropped_count, want.dropped_count);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = FN_READ;
        req_if.file_id      = '0;
        req_if.block_offset = '0;
        hold_off_request    = 1'b0;
        use_count           = '0;
        for (int i = 0; i < SLOTS; i++) begin
            pool_valid[i] = 1'b0;
            pool_dirty[i] = 1'b0;
            pool_file[i]  = '0;
            pool_block[i] = '0;
            pool_stamp[i] = '0;
        end
        set_idling(14, 63);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_single_file_pool();
        test_random_traffic(600);
        set_idling(63, 14);
        test_random_traffic(600);
        set_idling(0, 0);
        test_random_traffic(570);
        test_backpressure();

        wait_drain();
        repeat (2 * SCAN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d checked results, %0d long hold-off(s)",
                 items_sent, results_checked, holds_done);
        $display("  %0d hits, %0d fills, %0d dirty evictions,",
                 hits_seen, fills_seen, writebacks_seen);
        $display("  %0d dropping invalidates, %0d unused codes", drops_seen, spare_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/bplru_pkg.sv
design/bplru_req_if.sv
design/bplru_res_if.sv
design/bplru_ram.sv
design/bplru_scan.sv
design/block_buffer_pool_lru.sv
dv/block_buffer_pool_lru_tb.sv
